// ----- rtl/skinny_pkg.sv -----
// Shared types, S-box and tweakey permutation for the SKINNY-128-384 encryption pipeline.
package skinny_pkg;

  localparam int BLOCK_W = 128;
  localparam int RC_W    = 6;

  // Data carried from one round cell to the next.
  // Byte 0 of each 128-bit vector sits in bits [127:120].
  typedef struct packed {
    logic [BLOCK_W-1:0] state;
    logic [BLOCK_W-1:0] tk1;
    logic [BLOCK_W-1:0] tk2;
    logic [BLOCK_W-1:0] tk3;
    logic [RC_W-1:0]    rc;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h65,8'h4c,8'h6a,8'h42,8'h4b,8'h63,8'h43,8'h6b,8'h55,8'h75,8'h5a,8'h7a,8'h53,8'h73,8'h5b,8'h7b,
    8'h35,8'h8c,8'h3a,8'h81,8'h89,8'h33,8'h80,8'h3b,8'h95,8'h25,8'h98,8'h2a,8'h90,8'h23,8'h99,8'h2b,
    8'he5,8'hcc,8'he8,8'hc1,8'hc9,8'he0,8'hc0,8'he9,8'hd5,8'hf5,8'hd8,8'hf8,8'hd0,8'hf0,8'hd9,8'hf9,
    8'ha5,8'h1c,8'ha8,8'h12,8'h1b,8'ha0,8'h13,8'ha9,8'h05,8'hb5,8'h0a,8'hb8,8'h03,8'hb0,8'h0b,8'hb9,
    8'h32,8'h88,8'h3c,8'h85,8'h8d,8'h34,8'h84,8'h3d,8'h91,8'h22,8'h9c,8'h2c,8'h94,8'h24,8'h9d,8'h2d,
    8'h62,8'h4a,8'h6c,8'h45,8'h4d,8'h64,8'h44,8'h6d,8'h52,8'h72,8'h5c,8'h7c,8'h54,8'h74,8'h5d,8'h7d,
    8'ha1,8'h1a,8'hac,8'h15,8'h1d,8'ha4,8'h14,8'had,8'h02,8'hb1,8'h0c,8'hbc,8'h04,8'hb4,8'h0d,8'hbd,
    8'he1,8'hc8,8'hec,8'hc5,8'hcd,8'he4,8'hc4,8'hed,8'hd1,8'hf1,8'hdc,8'hfc,8'hd4,8'hf4,8'hdd,8'hfd,
    8'h36,8'h8e,8'h38,8'h82,8'h8b,8'h30,8'h83,8'h39,8'h96,8'h26,8'h9a,8'h28,8'h93,8'h20,8'h9b,8'h29,
    8'h66,8'h4e,8'h68,8'h41,8'h49,8'h60,8'h40,8'h69,8'h56,8'h76,8'h58,8'h78,8'h50,8'h70,8'h59,8'h79,
    8'ha6,8'h1e,8'haa,8'h11,8'h19,8'ha3,8'h10,8'hab,8'h06,8'hb6,8'h08,8'hba,8'h00,8'hb3,8'h09,8'hbb,
    8'he6,8'hce,8'hea,8'hc2,8'hcb,8'he3,8'hc3,8'heb,8'hd6,8'hf6,8'hda,8'hfa,8'hd3,8'hf3,8'hdb,8'hfb,
    8'h31,8'h8a,8'h3e,8'h86,8'h8f,8'h37,8'h87,8'h3f,8'h92,8'h21,8'h9e,8'h2e,8'h97,8'h27,8'h9f,8'h2f,
    8'h61,8'h48,8'h6e,8'h46,8'h4f,8'h67,8'h47,8'h6f,8'h51,8'h71,8'h5e,8'h7e,8'h57,8'h77,8'h5f,8'h7f,
    8'ha2,8'h18,8'hae,8'h16,8'h1f,8'ha7,8'h17,8'haf,8'h01,8'hb2,8'h0e,8'hbe,8'h07,8'hb7,8'h0f,8'hbf,
    8'he2,8'hca,8'hee,8'hc6,8'hcf,8'he7,8'hc7,8'hef,8'hd2,8'hf2,8'hde,8'hfe,8'hd7,8'hf7,8'hdf,8'hff
  };

  // Tweakey byte permutation: new byte i takes old byte PT[i].
  localparam logic [3:0] PT [16] = '{
    4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
    4'd0, 4'd1,  4'd2, 4'd3,  4'd4,  4'd5,  4'd6,  4'd7
  };

endpackage

// ----- rtl/skinny_cell.sv -----
// One SKINNY-128-384 round cell: round logic on the incoming item, then a register stage.
module skinny_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  skinny_pkg::item_t  in_item,
  output logic               valid,
  output skinny_pkg::item_t  item
);
  import skinny_pkg::*;

  logic [7:0]      s   [16];
  logic [7:0]      sr  [16];
  logic [7:0]      mc  [16];
  logic [7:0]      k1  [16];
  logic [7:0]      k2  [16];
  logic [7:0]      k3  [16];
  logic [7:0]      k1p [16];
  logic [7:0]      k2p [16];
  logic [7:0]      k3p [16];
  logic [RC_W-1:0] rc_next;
  item_t           item_next;

  always_comb begin
    rc_next = {in_item.rc[4:0], in_item.rc[5] ^ in_item.rc[4] ^ 1'b1};

    for (int i = 0; i < 16; i++) begin
      s[i]  = SBOX[in_item.state[BLOCK_W-1-8*i -: 8]];
      k1[i] = in_item.tk1[BLOCK_W-1-8*i -: 8];
      k2[i] = in_item.tk2[BLOCK_W-1-8*i -: 8];
      k3[i] = in_item.tk3[BLOCK_W-1-8*i -: 8];
    end

    // round constant and the fixed 0x2 into the third row
    s[0] = s[0] ^ {4'h0, rc_next[3:0]};
    s[4] = s[4] ^ {6'h00, rc_next[5:4]};
    s[8] = s[8] ^ 8'h02;

    // round tweakey onto the first two rows
    for (int i = 0; i < 8; i++) begin
      s[i] = s[i] ^ k1[i] ^ k2[i] ^ k3[i];
    end

    // row r rotates right by r
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sr[4*r+c] = s[4*r + ((c + 4 - r) % 4)];
      end
    end

    for (int c = 0; c < 4; c++) begin
      mc[c]    = sr[c] ^ sr[8+c] ^ sr[12+c];
      mc[4+c]  = sr[c];
      mc[8+c]  = sr[4+c] ^ sr[8+c];
      mc[12+c] = sr[c] ^ sr[8+c];
    end

    // tweakey schedule: permute, then clock the LFSRs on the top two rows
    for (int i = 0; i < 16; i++) begin
      k1p[i] = k1[PT[i]];
      k2p[i] = k2[PT[i]];
      k3p[i] = k3[PT[i]];
    end
    for (int i = 0; i < 8; i++) begin
      k2p[i] = {k2p[i][6:0], k2p[i][7] ^ k2p[i][5]};
      k3p[i] = {k3p[i][0] ^ k3p[i][6], k3p[i][7:1]};
    end

    for (int i = 0; i < 16; i++) begin
      item_next.state[BLOCK_W-1-8*i -: 8] = mc[i];
      item_next.tk1[BLOCK_W-1-8*i -: 8]   = k1p[i];
      item_next.tk2[BLOCK_W-1-8*i -: 8]   = k2p[i];
      item_next.tk3[BLOCK_W-1-8*i -: 8]   = k3p[i];
    end
    item_next.rc = rc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule

// ----- rtl/skinny_obuf.sv -----
// Output register with a skid entry; stalls the round chain only when both are full.
module skinny_obuf (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [skinny_pkg::BLOCK_W-1:0]  in_data,
  output logic                            advance,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [skinny_pkg::BLOCK_W-1:0]  m_tdata   // cipher_hi [63:0], cipher_lo [127:64]
);
  import skinny_pkg::*;

  logic               out_valid;
  logic [BLOCK_W-1:0] out_data;
  logic               skid_valid;
  logic [BLOCK_W-1:0] skid_data;
  logic               take;
  logic               incoming;

  assign advance  = !skid_valid;
  assign take     = out_valid && m_tready;
  assign incoming = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (incoming) begin
      if (!out_valid || take) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

  // byte 0 sits in the top of in_data; cipher_hi goes to the low half of tdata
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data[BLOCK_W/2-1:0], out_data[BLOCK_W-1:BLOCK_W/2]};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data while the output register is empty");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (incoming && out_valid && !m_tready) |=> skid_valid)
    else $error("result arriving behind a stalled output was not caught by the skid entry");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !take) |=> (skid_valid && $stable(skid_data)))
    else $error("skid entry changed or dropped while the output was stalled");

endmodule

// ----- rtl/skinny_128_384_encrypt.sv -----
// Top level of the SKINNY-128-384 encryption pipeline: round cell chain and output buffer.
//
// Usage:
//   s_* channel: one transfer carries a plaintext block and the full 384-bit tweakey.
//   m_* channel: one transfer carries the matching ciphertext, in the order of input.
//   The core is a chain of ROUND_COUNT round cells, one round per cell, each cell
//   registering its state, tweakey and round constant and handing them to the next
//   cell every cycle the chain is not held. Blocks are independent, so a new block
//   may enter every cycle. Throughput: one block per cycle while the receiver keeps up.
//   Path: an accepted block passes through the ROUND_COUNT cell registers and then
//   the output register before m_tvalid rises.
//   Stall: the output register has one skid entry behind it. s_tready depends only on
//   that skid entry, so the sender keeps feeding while one finished result waits;
//   once both entries are full the whole chain holds and s_tready drops.
//   Reset: rst clears all valid flags; blocks in flight are dropped and the block is
//   ready as soon as rst is released.
module skinny_128_384_encrypt #(
  parameter int ROUND_COUNT = 56
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // plain_hi [63:0], plain_lo [127:64], tk1_hi [191:128], tk1_lo [255:192],
  // tk2_hi [319:256], tk2_lo [383:320], tk3_hi [447:384], tk3_lo [511:448]
  input  logic [511:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cipher_hi [63:0], cipher_lo [127:64]
  output logic [127:0] m_tdata
);
  import skinny_pkg::*;

  logic  advance;
  logic  stage_valid [ROUND_COUNT+1];
  item_t stage_item  [ROUND_COUNT+1];

  // Unpack the transfer: each hi field holds bytes 0..7 with byte 0 on top.
  assign stage_valid[0]      = s_tvalid;
  assign stage_item[0].state = {s_tdata[63:0],    s_tdata[127:64]};
  assign stage_item[0].tk1   = {s_tdata[191:128], s_tdata[255:192]};
  assign stage_item[0].tk2   = {s_tdata[319:256], s_tdata[383:320]};
  assign stage_item[0].tk3   = {s_tdata[447:384], s_tdata[511:448]};
  assign stage_item[0].rc    = '0;

  // The whole chain moves together; the first cell takes in a valid block exactly when
  // a transfer completes on the slave side.
  assign s_tready = advance;

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    skinny_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .in_valid (stage_valid[g]),
      .in_item  (stage_item[g]),
      .valid    (stage_valid[g+1]),
      .item     (stage_item[g+1])
    );
  end

  skinny_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[ROUND_COUNT]),
    .in_data  (stage_item[ROUND_COUNT].state),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- test/tb_top.sv -----
// Testbench for the SKINNY-128-384 encryption pipeline: stream stimulus and ciphertext checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int ROUNDS = 56;
  // An honest run ends before the limit, even with every gap and stall at its longest.
  localparam int CYCLE_LIMIT = 400000;

  // Own copy of the 8-bit S-box, used by the ciphertext predictor only.
  localparam logic [7:0] SUB_BYTE [256] = '{
    8'h65,8'h4c,8'h6a,8'h42,8'h4b,8'h63,8'h43,8'h6b,8'h55,8'h75,8'h5a,8'h7a,8'h53,8'h73,8'h5b,8'h7b,
    8'h35,8'h8c,8'h3a,8'h81,8'h89,8'h33,8'h80,8'h3b,8'h95,8'h25,8'h98,8'h2a,8'h90,8'h23,8'h99,8'h2b,
    8'he5,8'hcc,8'he8,8'hc1,8'hc9,8'he0,8'hc0,8'he9,8'hd5,8'hf5,8'hd8,8'hf8,8'hd0,8'hf0,8'hd9,8'hf9,
    8'ha5,8'h1c,8'ha8,8'h12,8'h1b,8'ha0,8'h13,8'ha9,8'h05,8'hb5,8'h0a,8'hb8,8'h03,8'hb0,8'h0b,8'hb9,
    8'h32,8'h88,8'h3c,8'h85,8'h8d,8'h34,8'h84,8'h3d,8'h91,8'h22,8'h9c,8'h2c,8'h94,8'h24,8'h9d,8'h2d,
    8'h62,8'h4a,8'h6c,8'h45,8'h4d,8'h64,8'h44,8'h6d,8'h52,8'h72,8'h5c,8'h7c,8'h54,8'h74,8'h5d,8'h7d,
    8'ha1,8'h1a,8'hac,8'h15,8'h1d,8'ha4,8'h14,8'had,8'h02,8'hb1,8'h0c,8'hbc,8'h04,8'hb4,8'h0d,8'hbd,
    8'he1,8'hc8,8'hec,8'hc5,8'hcd,8'he4,8'hc4,8'hed,8'hd1,8'hf1,8'hdc,8'hfc,8'hd4,8'hf4,8'hdd,8'hfd,
    8'h36,8'h8e,8'h38,8'h82,8'h8b,8'h30,8'h83,8'h39,8'h96,8'h26,8'h9a,8'h28,8'h93,8'h20,8'h9b,8'h29,
    8'h66,8'h4e,8'h68,8'h41,8'h49,8'h60,8'h40,8'h69,8'h56,8'h76,8'h58,8'h78,8'h50,8'h70,8'h59,8'h79,
    8'ha6,8'h1e,8'haa,8'h11,8'h19,8'ha3,8'h10,8'hab,8'h06,8'hb6,8'h08,8'hba,8'h00,8'hb3,8'h09,8'hbb,
    8'he6,8'hce,8'hea,8'hc2,8'hcb,8'he3,8'hc3,8'heb,8'hd6,8'hf6,8'hda,8'hfa,8'hd3,8'hf3,8'hdb,8'hfb,
    8'h31,8'h8a,8'h3e,8'h86,8'h8f,8'h37,8'h87,8'h3f,8'h92,8'h21,8'h9e,8'h2e,8'h97,8'h27,8'h9f,8'h2f,
    8'h61,8'h48,8'h6e,8'h46,8'h4f,8'h67,8'h47,8'h6f,8'h51,8'h71,8'h5e,8'h7e,8'h57,8'h77,8'h5f,8'h7f,
    8'ha2,8'h18,8'hae,8'h16,8'h1f,8'ha7,8'h17,8'haf,8'h01,8'hb2,8'h0e,8'hbe,8'h07,8'hb7,8'h0f,8'hbf,
    8'he2,8'hca,8'hee,8'hc6,8'hcf,8'he7,8'hc7,8'hef,8'hd2,8'hf2,8'hde,8'hfe,8'hd7,8'hf7,8'hdf,8'hff
  };

  // Tweakey byte shuffle: new byte i takes old byte TK_PERM[i].
  localparam int TK_PERM [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // plain_hi, plain_lo, tk1_hi, tk1_lo, tk2_hi, tk2_lo, tk3_hi, tk3_lo (64 bits each, low first)
  logic [511:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // cipher_hi [63:0], cipher_lo [127:64]
  logic [127:0] m_tdata;

  logic [127:0] cipher_q [$];   // ciphertexts predicted for accepted blocks, oldest first
  int           err_cnt   = 0;
  int           cycle_cnt = 0;
  int           hold_req  = 0;  // long receiver hold-off requested by a test, in cycles
  bit           tx_idle   = 1'b0;
  bit           rx_idle   = 1'b0;

  skinny_128_384_encrypt #(.ROUND_COUNT(ROUNDS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predict the ciphertext of one transfer. Byte i of a 128-bit vector j lives in
  // 64-bit field 2j + i/8, with the lowest byte index in the field's top bits.
  function automatic logic [127:0] skinny_encrypt(input logic [511:0] blk);
    logic [7:0]   st [16];
    logic [7:0]   tk [3][16];
    logic [7:0]   nt [16];
    logic [7:0]   a, b, d, e;
    logic [5:0]   rc;
    logic [127:0] res;
    rc = '0;
    for (int i = 0; i < 16; i++) begin
      st[i] = blk[64 * (i / 8) + 56 - 8 * (i % 8) +: 8];
      for (int t = 0; t < 3; t++)
        tk[t][i] = blk[128 * (t + 1) + 64 * (i / 8) + 56 - 8 * (i % 8) +: 8];
    end
    for (int r = 0; r < ROUNDS; r++) begin
      for (int i = 0; i < 16; i++)
        st[i] = SUB_BYTE[st[i]];
      // Round constant LFSR: low nibble into byte 0, top two bits into byte 4.
      rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
      st[0] ^= {4'h0, rc[3:0]};
      st[4] ^= {6'h0, rc[5:4]};
      st[8] ^= 8'h02;
      for (int i = 0; i < 8; i++)
        st[i] ^= tk[0][i] ^ tk[1][i] ^ tk[2][i];
      for (int t = 0; t < 3; t++) begin
        for (int i = 0; i < 16; i++)
          nt[i] = tk[t][TK_PERM[i]];
        for (int i = 0; i < 16; i++)
          tk[t][i] = nt[i];
      end
      for (int i = 0; i < 8; i++) begin
        tk[1][i] = {tk[1][i][6:0], tk[1][i][7] ^ tk[1][i][5]};
        tk[2][i] = {tk[2][i][0] ^ tk[2][i][6], tk[2][i][7:1]};
      end
      // ShiftRows: row r rotates right by r.
      for (int rw = 0; rw < 4; rw++)
        for (int c = 0; c < 4; c++)
          nt[4 * rw + c] = st[4 * rw + ((c + 4 - rw) & 3)];
      for (int i = 0; i < 16; i++)
        st[i] = nt[i];
      for (int c = 0; c < 4; c++) begin
        a = st[c];
        b = st[4 + c];
        d = st[8 + c];
        e = st[12 + c];
        st[c]      = a ^ d ^ e;
        st[4 + c]  = a;
        st[8 + c]  = b ^ d;
        st[12 + c] = a ^ d;
      end
    end
    for (int i = 0; i < 16; i++)
      res[64 * (i / 8) + 56 - 8 * (i % 8) +: 8] = st[i];
    return res;
  endfunction

  // Predict at every accepted input transfer.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      cipher_q.push_back(skinny_encrypt(s_tdata));
  end

  // Check every accepted output transfer against the oldest prediction, field by field.
  always @(posedge clk) begin
    logic [127:0] exp_c;
    if (!rst && m_tvalid && m_tready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected ciphertext, expected none, actual %h", $time, m_tdata);
        err_cnt++;
      end else begin
        exp_c = cipher_q.pop_front();
        if (m_tdata[63:0] !== exp_c[63:0]) begin
          $display("%0t: cipher_hi mismatch, expected %h, actual %h",
                   $time, exp_c[63:0], m_tdata[63:0]);
          err_cnt++;
        end
        if (m_tdata[127:64] !== exp_c[127:64]) begin
          $display("%0t: cipher_lo mismatch, expected %h, actual %h",
                   $time, exp_c[127:64], m_tdata[127:64]);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random stall bursts while rx_idle is set, plus a long hold-off on request.
  // The hold-off is counted here, so the sender keeps offering blocks meanwhile.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if the cycle counter reaches the limit.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[skinny_128_384_encrypt] ERROR");
    $finish;
  end

  // Offer one block and hold it until the transfer happens. Called at a rising edge,
  // returns at the edge of the transfer with tvalid still high.
  task automatic send_block(input logic [511:0] blk);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= blk;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop tvalid and wait until every predicted ciphertext has arrived. Sample the
  // queue on the falling edge so the monitors of the rising edge have run.
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (cipher_q.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_field;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [511:0] rand_block;
    logic [511:0] blk;
    for (int f = 0; f < 8; f++)
      blk[64 * f +: 64] = rand_field();
    return blk;
  endfunction

  // Extremes of every field, alternating patterns, single set bits, a published vector.
  task automatic test_directed;
    send_block('0);
    send_block('1);
    send_block({8{64'haaaa_aaaa_aaaa_aaaa}});
    send_block({8{64'h5555_5555_5555_5555}});
    // One field all ones, the rest zero, for each of the eight fields.
    for (int f = 0; f < 8; f++) begin
      logic [511:0] blk;
      blk = '0;
      blk[64 * f +: 64] = '1;
      send_block(blk);
    end
    // Each field all ones on its own was covered above;
    // add lone top and bottom bits of the plaintext and the last tweakey byte.
    send_block({448'h0, 64'h8000_0000_0000_0001});
    send_block({64'h0000_0000_0000_0001, 448'h0});
    send_block({64'h8000_0000_0000_0000, 384'h0, 64'h0000_0000_0000_0001});
    // Published SKINNY-128-384 vector; the predictor decides the expected ciphertext.
    send_block({64'h8cef952618c3ebe8, 64'hab1afac2611012cd,
                64'hdfe9c8293fbea9a5, 64'hab588a34a47f1ab2,
                64'hd296339301797449, 64'hdf889548cfc7ea52,
                64'h9f44e92b08f550cb, 64'ha3994b66ad85a345});
    drain();
  endtask

  // Random blocks with random gaps on both sides.
  task automatic test_random(input int count);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int k = 0; k < count; k++)
      send_block(rand_block());
    drain();
  endtask

  // Hold the receiver off for a long stretch while blocks keep coming, so the chain
  // fills up and s_tready drops.
  task automatic test_backpressure;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 300;
    for (int k = 0; k < 150; k++)
      send_block(rand_block());
    drain();
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_pause;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 20; k++)
        send_block(rand_block());
      drain();
    end
  endtask

  // Back-to-back at full rate with no idling at all.
  task automatic test_full_rate;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int k = 0; k < 150; k++)
      send_block(rand_block());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(1100);
    test_backpressure();
    test_pause();
    test_full_rate();

    // Allow any stray result to show up after the last expected one.
    repeat (ROUNDS + 20) @(posedge clk);
    if (err_cnt == 0 && cipher_q.size() == 0) begin
      $display("[skinny_128_384_encrypt] OK");
    end else begin
      $display("[skinny_128_384_encrypt] ERROR");
    end
    $finish;
  end

endmodule
